// ----- hw/rtl/lfbd_pkg.sv -----
package lfbd_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int OFF_BITS      = 12;
    localparam int LEN_BITS      = 5;
    localparam int CFG_IDX_BITS  = 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_BIAS  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_SIZE = 1'b1;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_ITEM  = 2'd1,
        PH_TOKHI = 2'd2
    } phase_t;

    typedef enum logic {
        CMD_LIT   = 1'b0,
        CMD_MATCH = 1'b1
    } cmd_kind_t;

    // One unit of work for the copy engine: a literal or a clipped match.
    typedef struct packed {
        cmd_kind_t                kind;
        logic                     last;
        logic [LEN_BITS-1:0]      len;
        logic [OFF_BITS-1:0]      off;
        logic [BYTE_BITS-1:0]     lit;
    } cmd_t;

endpackage

// ----- hw/rtl/lzss_flag_byte_decompressor_top.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] = in_byte
// m_*       out  m_tvalid/m_tready  m_tdata[7:0] = out_byte, m_tlast = last
// cfg_*     in   cfg_we             cfg_index (0 match_bias, 1 output_size), cfg_data
//
// Flag, literal and token bytes are taken one per cycle while the 4-entry command
// queue has room; a literal moves from the queue to the output register when the copy
// engine is idle and that register is free. A match of 2..18 bytes (fewer if clipped)
// takes a queue pop, a first history read, then a byte per cycle from history RAM.
// Reset clears control state only; the history RAM is not cleared and needs no pass.
// Low m_tready holds the output register and the copy; a full queue drops s_tready.
module lzss_flag_byte_decompressor_top #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int SIZE_BITS    = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lfbd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [SIZE_BITS-1:0]               cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] in_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tlast
);

    logic            push_valid;
    logic            push_ready;
    lfbd_pkg::cmd_t  push_cmd;
    logic            pop_valid;
    logic            pop_ready;
    lfbd_pkg::cmd_t  pop_cmd;

    lfbd_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_cmd)
    );

    lfbd_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    lfbd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ----- hw/rtl/lfbd_front.sv -----
module lfbd_front #(
    parameter int SIZE_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lfbd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [SIZE_BITS-1:0]               cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lfbd_pkg::BYTE_BITS-1:0]     in_byte,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output lfbd_pkg::cmd_t                     cmd
);

    lfbd_pkg::phase_t                 phase_reg, phase_next;
    logic [lfbd_pkg::BYTE_BITS-1:0]   flag_bits_reg, flag_bits_next;
    logic [2:0]                       flag_index_reg, flag_index_next;
    logic [lfbd_pkg::BYTE_BITS-1:0]   token_low_reg, token_low_next;
    logic [SIZE_BITS-1:0]             bytes_left_reg, bytes_left_next;
    logic [1:0]                       match_bias_reg;
    logic [SIZE_BITS-1:0]             output_size_reg;

    logic                             accept;
    logic [SIZE_BITS-1:0]             bl_load;
    logic [SIZE_BITS-1:0]             bl_after;
    logic [1:0]                       bias_eff;
    logic [lfbd_pkg::LEN_BITS-1:0]    full_len;
    logic [lfbd_pkg::LEN_BITS-1:0]    clip_len;
    logic [2:0]                       idx_inc;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && cmd_ready;
    assign idx_inc  = flag_index_reg + 3'd1;

    always_comb
    begin
        case (match_bias_reg)
            2'd0:    bias_eff = 2'd1;
            2'd3:    bias_eff = 2'd2;
            default: bias_eff = match_bias_reg;
        endcase
        full_len = lfbd_pkg::LEN_BITS'(token_low_reg[3:0]) + lfbd_pkg::LEN_BITS'(bias_eff)
                   + lfbd_pkg::LEN_BITS'(1);
        if (bytes_left_reg < SIZE_BITS'(full_len))
        begin
            clip_len = bytes_left_reg[lfbd_pkg::LEN_BITS-1:0];
        end
        else
        begin
            clip_len = full_len;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flag_index_next = flag_index_reg;
        token_low_next  = token_low_reg;
        bytes_left_next = bytes_left_reg;
        bl_load         = bytes_left_reg;
        bl_after        = bytes_left_reg;
        cmd_valid       = 1'b0;
        cmd.kind        = lfbd_pkg::CMD_LIT;
        cmd.last        = 1'b0;
        cmd.len         = lfbd_pkg::LEN_BITS'(1);
        cmd.off         = {token_low_reg[7:4], in_byte};
        cmd.lit         = in_byte;

        if (accept)
        begin
            case (phase_reg)
                lfbd_pkg::PH_FLAG:
                begin
                    if (bytes_left_reg == '0)
                    begin
                        bl_load = output_size_reg;
                    end
                    bytes_left_next = bl_load;
                    flag_bits_next  = in_byte;
                    flag_index_next = 3'd0;
                    phase_next      = (bl_load == '0) ? lfbd_pkg::PH_FLAG : lfbd_pkg::PH_ITEM;
                end
                lfbd_pkg::PH_ITEM:
                begin
                    if (flag_bits_reg[flag_index_reg])
                    begin
                        bl_after        = bytes_left_reg - SIZE_BITS'(1);
                        cmd_valid       = 1'b1;
                        cmd.kind        = lfbd_pkg::CMD_LIT;
                        cmd.last        = (bl_after == '0);
                        bytes_left_next = bl_after;
                        flag_index_next = idx_inc;
                        phase_next      = (idx_inc == 3'd0 || bl_after == '0) ?
                                          lfbd_pkg::PH_FLAG : lfbd_pkg::PH_ITEM;
                        if (bl_after == '0)
                        begin
                            flag_index_next = 3'd0;
                        end
                    end
                    else
                    begin
                        token_low_next = in_byte;
                        phase_next     = lfbd_pkg::PH_TOKHI;
                    end
                end
                lfbd_pkg::PH_TOKHI:
                begin
                    // token low nibble sits in token_low; distance offset is the upper 12 bits
                    bl_after        = bytes_left_reg - SIZE_BITS'(clip_len);
                    cmd_valid       = 1'b1;
                    cmd.kind        = lfbd_pkg::CMD_MATCH;
                    cmd.last        = (bl_after == '0);
                    cmd.len         = clip_len;
                    cmd.off         = {in_byte, token_low_reg[7:4]};
                    bytes_left_next = bl_after;
                    flag_index_next = idx_inc;
                    phase_next      = (idx_inc == 3'd0 || bl_after == '0) ?
                                      lfbd_pkg::PH_FLAG : lfbd_pkg::PH_ITEM;
                    if (bl_after == '0)
                    begin
                        flag_index_next = 3'd0;
                    end
                end
                default:
                begin
                    phase_next = lfbd_pkg::PH_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lfbd_pkg::PH_FLAG;
            flag_bits_reg   <= '0;
            flag_index_reg  <= '0;
            token_low_reg   <= '0;
            bytes_left_reg  <= '0;
            match_bias_reg  <= 2'd1;
            output_size_reg <= SIZE_BITS'(1);
        end
        else
        begin
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flag_index_reg <= flag_index_next;
            token_low_reg  <= token_low_next;
            bytes_left_reg <= bytes_left_next;
            if (cfg_we && cfg_index == lfbd_pkg::CFG_MATCH_BIAS)
            begin
                match_bias_reg <= cfg_data[1:0];
            end
            if (cfg_we && cfg_index == lfbd_pkg::CFG_OUTPUT_SIZE)
            begin
                output_size_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- hw/rtl/lfbd_cmd_fifo.sv -----
module lfbd_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lfbd_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lfbd_pkg::cmd_t  pop_data
);

    lfbd_pkg::cmd_t                       slot_reg [lfbd_pkg::FIFO_DEPTH];
    logic [lfbd_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lfbd_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lfbd_pkg::FIFO_CNT_BITS-1:0]   count_reg, count_next;
    logic                                 do_push;
    logic                                 do_pop;

    assign push_ready = (count_reg != lfbd_pkg::FIFO_CNT_BITS'(lfbd_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + lfbd_pkg::FIFO_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + lfbd_pkg::FIFO_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + lfbd_pkg::FIFO_CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - lfbd_pkg::FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/lfbd_back.sv -----
module lfbd_back #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  lfbd_pkg::cmd_t                  cmd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lfbd_pkg::BYTE_BITS-1:0]  out_byte,
    output logic                            out_last
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W   = (AW+1)'(WINDOW_DEPTH);

    logic [lfbd_pkg::BYTE_BITS-1:0]  hist_mem [WINDOW_DEPTH];
    logic [lfbd_pkg::BYTE_BITS-1:0]  q_reg;

    logic                            busy_reg, busy_next;
    logic                            pend_reg, pend_next;
    logic [AW-1:0]                   wp_reg, wp_next;
    logic [AW-1:0]                   rd_reg, rd_next;
    logic [lfbd_pkg::LEN_BITS-1:0]   cnt_reg, cnt_next;
    logic                            mlast_reg, mlast_next;
    logic                            fwd_reg, fwd_next;
    logic [lfbd_pkg::BYTE_BITS-1:0]  fwd_byte_reg, fwd_byte_next;
    logic                            out_valid_reg, out_valid_next;
    logic [lfbd_pkg::BYTE_BITS-1:0]  out_byte_reg, out_byte_next;
    logic                            out_last_reg, out_last_next;

    logic                            can_emit;
    logic                            we;
    logic [lfbd_pkg::BYTE_BITS-1:0]  wdata;
    logic                            re;
    logic [lfbd_pkg::BYTE_BITS-1:0]  copy_byte;
    logic [AW:0]                     start_wide;
    logic [AW-1:0]                   start_addr;
    logic [AW-1:0]                   wp_inc;
    logic [AW-1:0]                   rd_inc;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign can_emit  = !out_valid_reg || out_ready;
    assign wp_inc    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
    assign rd_inc    = (rd_reg == LAST_ADDR) ? '0 : rd_reg + AW'(1);
    assign copy_byte = fwd_reg ? fwd_byte_reg : q_reg;

    // start = write_pos - (offset + 1), wrapped into the window
    always_comb
    begin
        start_wide = {1'b0, wp_reg} + DEPTH_W - (AW+1)'(cmd.off) - (AW+1)'(1);
        if (start_wide >= DEPTH_W)
        begin
            start_wide = start_wide - DEPTH_W;
        end
        start_addr = start_wide[AW-1:0];
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        wp_next        = wp_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;
        mlast_next     = mlast_reg;
        fwd_next       = fwd_reg;
        fwd_byte_next  = fwd_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        cmd_ready      = 1'b0;
        we             = 1'b0;
        wdata          = cmd.lit;
        re             = 1'b0;

        if (!busy_reg)
        begin
            if (cmd_valid)
            begin
                if (cmd.kind == lfbd_pkg::CMD_LIT)
                begin
                    if (can_emit)
                    begin
                        cmd_ready      = 1'b1;
                        we             = 1'b1;
                        wdata          = cmd.lit;
                        wp_next        = wp_inc;
                        out_valid_next = 1'b1;
                        out_byte_next  = cmd.lit;
                        out_last_next  = cmd.last;
                    end
                end
                else
                begin
                    cmd_ready  = 1'b1;
                    busy_next  = 1'b1;
                    pend_next  = 1'b0;
                    cnt_next   = cmd.len;
                    rd_next    = start_addr;
                    mlast_next = cmd.last;
                end
            end
        end
        else if (!pend_reg)
        begin
            // prime the read for the first byte of the match
            re        = 1'b1;
            fwd_next  = 1'b0;
            rd_next   = rd_inc;
            pend_next = 1'b1;
        end
        else if (can_emit)
        begin
            we             = 1'b1;
            wdata          = copy_byte;
            wp_next        = wp_inc;
            out_valid_next = 1'b1;
            out_byte_next  = copy_byte;
            out_last_next  = mlast_reg && (cnt_reg == lfbd_pkg::LEN_BITS'(1));
            cnt_next       = cnt_reg - lfbd_pkg::LEN_BITS'(1);
            if (cnt_reg == lfbd_pkg::LEN_BITS'(1))
            begin
                busy_next = 1'b0;
                pend_next = 1'b0;
            end
            else
            begin
                // bypass the byte being written now when the next read hits it
                re            = 1'b1;
                fwd_next      = (rd_reg == wp_reg);
                fwd_byte_next = copy_byte;
                rd_next       = rd_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[wp_reg] <= wdata;
        end
        if (re)
        begin
            q_reg <= hist_mem[rd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg       <= rd_next;
        cnt_reg      <= cnt_next;
        mlast_reg    <= mlast_next;
        fwd_reg      <= fwd_next;
        fwd_byte_reg <= fwd_byte_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
